/* src/rgc_pkg.sv */
// ----------------------------------------------------------------------------
// rgc_pkg: shared types and constants of the ray ground classifier
// Field widths, configuration register indexes and reset values, and the
// structs that carry configuration and per-ray state between modules.
// ----------------------------------------------------------------------------
package rgc_pkg;

  localparam int RADIUS_W    = 18;
  localparam int HEIGHT_W    = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int SLOPE_FRAC  = 14;
  localparam int PROD_W      = CFG_W + RADIUS_W;
  localparam int MAG_W       = PROD_W - SLOPE_FRAC;
  localparam int WIDE_W      = MAG_W + 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_SLOPE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GENERAL_SLOPE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CONCENTRIC    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_HEIGHT    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_RECLASS       = 3'd4;

  localparam logic [CFG_W-1:0] RST_LOCAL_SLOPE   = 16'd1433;
  localparam logic [CFG_W-1:0] RST_GENERAL_SLOPE = 16'd859;
  localparam logic [CFG_W-1:0] RST_CONCENTRIC    = 16'd10;
  localparam logic [CFG_W-1:0] RST_MIN_HEIGHT    = 16'd50;
  localparam logic [CFG_W-1:0] RST_RECLASS       = 16'd200;

  typedef struct packed {
    logic [CFG_W-1:0] local_slope;
    logic [CFG_W-1:0] general_slope;
    logic [CFG_W-1:0] concentric;
    logic [CFG_W-1:0] min_height;
    logic [CFG_W-1:0] reclass;
  } cfg_t;

  typedef struct packed {
    logic [RADIUS_W-1:0]        radius;
    logic signed [HEIGHT_W-1:0] height;
    logic                       ground;
  } ray_state_t;

endpackage

/* src/rgc_point_if.sv */
// ----------------------------------------------------------------------------
// rgc_point_if: point request channel
// Valid/ready channel carrying one lidar point per request.
// ----------------------------------------------------------------------------
interface rgc_point_if #(
  parameter int TAG_BITS = 32
);
  logic                                valid;
  logic                                ready;
  logic [rgc_pkg::RADIUS_W-1:0]        radius;
  logic signed [rgc_pkg::HEIGHT_W-1:0] height;
  logic                                ray_start;
  logic [TAG_BITS-1:0]                 point_tag;

  modport source (output valid, output radius, output height, output ray_start,
                  output point_tag, input ready);
  modport sink (input valid, input radius, input height, input ray_start,
                input point_tag, output ready);
endinterface

/* src/rgc_result_if.sv */
// ----------------------------------------------------------------------------
// rgc_result_if: classification result channel
// Valid/ready channel carrying one ground decision per request.
// ----------------------------------------------------------------------------
interface rgc_result_if #(
  parameter int TAG_BITS = 32
);
  logic                valid;
  logic                ready;
  logic                is_ground;
  logic [TAG_BITS-1:0] tag_out;

  modport source (output valid, output is_ground, output tag_out, input ready);
  modport sink (input valid, input is_ground, input tag_out, output ready);
endinterface

/* src/rgc_judge.sv */
// ----------------------------------------------------------------------------
// rgc_judge: ground decision for one point
// Forms the local and general height thresholds from the slope ratios and
// judges the point against the previous point of its ray.
// ----------------------------------------------------------------------------
module rgc_judge (
  input  rgc_pkg::cfg_t                       cfg,
  input  rgc_pkg::ray_state_t                 prev,
  input  logic [rgc_pkg::RADIUS_W-1:0]        radius,
  input  logic signed [rgc_pkg::HEIGHT_W-1:0] height,
  input  logic                                ray_start,
  output logic                                ground
);
  localparam int RW = rgc_pkg::RADIUS_W;
  localparam int HW = rgc_pkg::HEIGHT_W;
  localparam int PW = rgc_pkg::PROD_W;
  localparam int MW = rgc_pkg::MAG_W;
  localparam int WW = rgc_pkg::WIDE_W;
  localparam int FR = rgc_pkg::SLOPE_FRAC;
  localparam int CW = rgc_pkg::CFG_W;

  logic [RW-1:0]        base_radius;
  logic signed [HW-1:0] base_height;
  logic                 base_ground;
  logic signed [RW:0]   delta;
  logic [RW-1:0]        delta_mag;
  logic [PW-1:0]        loc_prod;
  logic [PW-1:0]        gen_prod;
  logic signed [MW:0]   loc_raw;
  logic signed [MW:0]   loc;
  logic signed [RW:0]   concentric_w;
  logic signed [RW:0]   reclass_w;
  logic signed [MW:0]   min_w;
  logic signed [WW-1:0] h_w;
  logic signed [WW-1:0] lh_w;
  logic signed [WW-1:0] loc_w;
  logic signed [WW-1:0] gen_w;
  logic signed [WW-1:0] upper;
  logic signed [WW-1:0] lower;
  logic                 in_band;
  logic                 in_cone;
  logic                 reclass_ok;

  always_comb begin
    base_radius = ray_start ? '0 : prev.radius;
    base_height = ray_start ? '0 : prev.height;
    base_ground = ray_start ? 1'b0 : prev.ground;

    delta     = $signed({1'b0, radius}) - $signed({1'b0, base_radius});
    delta_mag = delta[RW] ? RW'(-delta) : delta[RW-1:0];

    loc_prod = PW'(cfg.local_slope) * PW'(delta_mag);
    gen_prod = PW'(cfg.general_slope) * PW'(radius);

    loc_raw = delta[RW] ? -$signed({1'b0, loc_prod[PW-1:FR]})
                        : $signed({1'b0, loc_prod[PW-1:FR]});

    concentric_w = $signed({{(RW+1-CW){1'b0}}, cfg.concentric});
    reclass_w    = $signed({{(RW+1-CW){1'b0}}, cfg.reclass});
    min_w        = $signed({{(MW+1-CW){1'b0}}, cfg.min_height});

    loc = (delta > concentric_w && loc_raw < min_w) ? min_w : loc_raw;

    h_w   = {{(WW-HW){height[HW-1]}}, height};
    lh_w  = {{(WW-HW){base_height[HW-1]}}, base_height};
    loc_w = {{(WW-MW-1){loc[MW]}}, loc};
    gen_w = $signed({{(WW-MW){1'b0}}, gen_prod[PW-1:FR]});

    upper = lh_w + loc_w;
    lower = lh_w - loc_w;

    in_band    = (h_w <= upper) && (h_w >= lower);
    in_cone    = (h_w <= gen_w) && (h_w >= -gen_w);
    reclass_ok = (delta > reclass_w) && (h_w <= loc_w) && (h_w >= -loc_w);

    ground = in_band ? (base_ground || in_cone) : reclass_ok;
  end

endmodule

/* src/ray_ground_classifier_unit.sv */
// ----------------------------------------------------------------------------
// ray_ground_classifier_unit: per-ray lidar ground classifier
// Judges each point of a radius-sorted ray as ground or not ground.
// ----------------------------------------------------------------------------
// Usage:
//   point  : valid/ready request channel, one point per request (radius,
//            height, ray_start, point_tag). Points of a ray arrive in order.
//   result : valid/ready channel, one request per point (is_ground, tag_out)
//            in point order.
//   cfg_we/cfg_index/cfg_data: register write port, write only while idle.
// From point acceptance to the earliest result acceptance, a point passes
// the input register, where the decision is formed by one multiply per
// threshold and the compares, and then the result register.
// Throughput is one point per cycle while the receiver does not stall; the
// previous-point state is updated as a point moves into the result
// register, so the next point sees it at once.
// When the receiver stalls, the result register holds, the input register
// holds or fills, and point.ready stays low while both are full.
// Reset clears both stages, the previous-point state and the registers to
// their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ray_ground_classifier_unit #(
  parameter int TAG_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rgc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rgc_pkg::CFG_W-1:0]          cfg_data,
  rgc_point_if.sink                          point,
  rgc_result_if.source                       result
);

  rgc_pkg::cfg_t       cfg;
  rgc_pkg::ray_state_t state;

  logic                                s1_valid;
  logic [rgc_pkg::RADIUS_W-1:0]        s1_radius;
  logic signed [rgc_pkg::HEIGHT_W-1:0] s1_height;
  logic                                s1_ray_start;
  logic [TAG_BITS-1:0]                 s1_tag;
  logic                                s1_move;
  logic                                s1_ground;

  logic                res_valid;
  logic                res_ground;
  logic [TAG_BITS-1:0] res_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.local_slope   <= rgc_pkg::RST_LOCAL_SLOPE;
      cfg.general_slope <= rgc_pkg::RST_GENERAL_SLOPE;
      cfg.concentric    <= rgc_pkg::RST_CONCENTRIC;
      cfg.min_height    <= rgc_pkg::RST_MIN_HEIGHT;
      cfg.reclass       <= rgc_pkg::RST_RECLASS;
    end else if (cfg_we) begin
      case (cfg_index)
        rgc_pkg::CFG_LOCAL_SLOPE:   cfg.local_slope   <= cfg_data;
        rgc_pkg::CFG_GENERAL_SLOPE: cfg.general_slope <= cfg_data;
        rgc_pkg::CFG_CONCENTRIC:    cfg.concentric    <= cfg_data;
        rgc_pkg::CFG_MIN_HEIGHT:    cfg.min_height    <= cfg_data;
        rgc_pkg::CFG_RECLASS:       cfg.reclass       <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_move     = s1_valid && (!res_valid || result.ready);
  assign point.ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (point.ready) begin
      s1_valid <= point.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (point.valid && point.ready) begin
      s1_radius    <= point.radius;
      s1_height    <= point.height;
      s1_ray_start <= point.ray_start;
      s1_tag       <= point.point_tag;
    end
  end

  rgc_judge u_judge (
    .cfg       (cfg),
    .prev      (state),
    .radius    (s1_radius),
    .height    (s1_height),
    .ray_start (s1_ray_start),
    .ground    (s1_ground)
  );

  // advance the previous-point state as the point leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_move) begin
      state.radius <= s1_radius;
      state.height <= s1_height;
      state.ground <= s1_ground;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_move) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res_ground <= s1_ground;
      res_tag    <= s1_tag;
    end
  end

  assign result.valid     = res_valid;
  assign result.is_ground = res_ground;
  assign result.tag_out   = res_tag;

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && res_valid && !result.ready) |=> (s1_valid && $stable(s1_tag)))
    else $error("input register lost a point during a result stall");

  a_state_update: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> (state.radius == $past(s1_radius)) && (res_ground == state.ground))
    else $error("previous-point state does not match the delivered point");
`endif

endmodule
